/* rtl/core/csr_smv_pkg.sv */
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector dot core: shared package
// Types, codes and fixed widths used by the controller and the datapath.
// ----------------------------------------------------------------------------
package csr_smv_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 48;
  localparam int HI_W    = SUM_W - VALUE_W;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int FRAC_W  = 16;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(SUM_MAX) + PROD_W'(1);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TERM    = 2'd1,
    CMD_END_ROW = 2'd2,
    CMD_START   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLEAR,
    ST_READ,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCALE,
    ST_ACCUM
  } state_t;

  typedef struct packed {
    logic latch;
    logic mem_we;
    logic mem_re;
    logic abs_en;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic accum;
    logic emit;
    logic clear_all;
    logic clear_row;
  } ctrl_t;

  typedef struct packed {
    cmd_t op;
    logic idx_ok;
    logic row_ok;
  } status_t;

endpackage

/* rtl/core/csr_smv_ram.sv */
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector dot core: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csr_smv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/csr_smv_ctrl.sv */
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector dot core: controller
// Sequences each command through the datapath, one command at a time.
// ----------------------------------------------------------------------------
module csr_smv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            cmd,
  input  csr_smv_pkg::status_t  status,
  output csr_smv_pkg::ctrl_t    ctrl,
  output logic                  busy
);

  csr_smv_pkg::state_t state;
  csr_smv_pkg::state_t state_next;
  logic                skip;

  assign skip = ((status.op == csr_smv_pkg::CMD_TERM) && !status.idx_ok) ||
                ((status.op == csr_smv_pkg::CMD_END_ROW) && !status.row_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csr_smv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      csr_smv_pkg::ST_IDLE: begin
        if (start) begin
          unique case (csr_smv_pkg::cmd_t'(cmd))
            csr_smv_pkg::CMD_LOAD:    state_next = csr_smv_pkg::ST_WRITE;
            csr_smv_pkg::CMD_TERM:    state_next = csr_smv_pkg::ST_READ;
            csr_smv_pkg::CMD_END_ROW: state_next = csr_smv_pkg::ST_READ;
            csr_smv_pkg::CMD_START:   state_next = csr_smv_pkg::ST_CLEAR;
          endcase
        end
      end
      csr_smv_pkg::ST_WRITE:  state_next = csr_smv_pkg::ST_IDLE;
      csr_smv_pkg::ST_CLEAR:  state_next = csr_smv_pkg::ST_IDLE;
      csr_smv_pkg::ST_READ: begin
        state_next = skip ? csr_smv_pkg::ST_IDLE : csr_smv_pkg::ST_ABS;
      end
      csr_smv_pkg::ST_ABS:    state_next = csr_smv_pkg::ST_MUL_LO;
      csr_smv_pkg::ST_MUL_LO: state_next = csr_smv_pkg::ST_MUL_HI;
      csr_smv_pkg::ST_MUL_HI: state_next = csr_smv_pkg::ST_SCALE;
      csr_smv_pkg::ST_SCALE:  state_next = csr_smv_pkg::ST_ACCUM;
      csr_smv_pkg::ST_ACCUM:  state_next = csr_smv_pkg::ST_IDLE;
      default:                state_next = csr_smv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    unique case (state)
      csr_smv_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ctrl.latch = start;
      end
      csr_smv_pkg::ST_WRITE:  ctrl.mem_we    = status.idx_ok;
      csr_smv_pkg::ST_CLEAR:  ctrl.clear_all = 1'b1;
      csr_smv_pkg::ST_READ: begin
        ctrl.mem_re    = !skip;
        ctrl.clear_row = (status.op == csr_smv_pkg::CMD_END_ROW) && !status.row_ok;
      end
      csr_smv_pkg::ST_ABS:    ctrl.abs_en = 1'b1;
      csr_smv_pkg::ST_MUL_LO: ctrl.mul_lo = 1'b1;
      csr_smv_pkg::ST_MUL_HI: ctrl.mul_hi = 1'b1;
      csr_smv_pkg::ST_SCALE:  ctrl.scale  = 1'b1;
      csr_smv_pkg::ST_ACCUM: begin
        ctrl.accum = 1'b1;
        ctrl.emit  = (status.op == csr_smv_pkg::CMD_END_ROW);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/core/csr_smv_dp.sv */
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector dot core: datapath
// Vector store, shared multiplier, scaling with clamp, and saturating sums.
// ----------------------------------------------------------------------------
module csr_smv_dp #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  csr_smv_pkg::ctrl_t                          ctrl,
  output csr_smv_pkg::status_t                        status,
  input  logic [1:0]                                  cmd,
  input  logic [csr_smv_pkg::INDEX_W-1:0]             index,
  input  logic signed [csr_smv_pkg::VALUE_W-1:0]      value,
  output logic [csr_smv_pkg::INDEX_W-1:0]             row_index,
  output logic signed [csr_smv_pkg::SUM_W-1:0]        row_value,
  output logic signed [csr_smv_pkg::SUM_W-1:0]        dot_value,
  output logic                                        saturated,
  output logic                                        done
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int CW = $clog2(VECTOR_DEPTH + 1);
  localparam int VW = csr_smv_pkg::VALUE_W;
  localparam int SW = csr_smv_pkg::SUM_W;
  localparam int HW = csr_smv_pkg::HI_W;
  localparam int PW = csr_smv_pkg::PROD_W;
  localparam int FW = csr_smv_pkg::FRAC_W;

  csr_smv_pkg::cmd_t                  op;
  logic [csr_smv_pkg::INDEX_W-1:0]    idx;
  logic signed [VW-1:0]               val;
  logic signed [SW-1:0]               row_sum;
  logic signed [SW-1:0]               dot_sum;
  logic [CW-1:0]                      row_counter;
  logic                               sat_flag;
  logic                               neg;
  logic [HW-1:0]                      ah;
  logic [VW-1:0]                      al;
  logic [VW-1:0]                      ub;
  logic [PW-1:0]                      p_lo;
  logic [SW-1:0]                      p_hi;
  logic signed [SW-1:0]               term;
  logic                               term_sat;

  logic [VW-1:0]                      rdata;
  logic [AW-1:0]                      raddr;
  logic signed [SW-1:0]               a_sel;
  logic [SW-1:0]                      ua;
  logic [VW-1:0]                      mul_a;
  logic [PW-1:0]                      prod;
  logic [PW-1:0]                      mag;
  logic signed [SW-1:0]               term_next;
  logic                               term_sat_next;
  logic signed [SW-1:0]               acc_sel;
  logic signed [SW:0]                 acc_wide;
  logic signed [SW-1:0]               acc_next;
  logic                               add_sat;

  assign status.op     = op;
  assign status.idx_ok = 32'(idx) < 32'(VECTOR_DEPTH);
  assign status.row_ok = 32'(row_counter) < 32'(VECTOR_DEPTH);

  assign raddr = (op == csr_smv_pkg::CMD_END_ROW) ? AW'(row_counter) : AW'(idx);

  csr_smv_ram #(
    .WIDTH (VW),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .waddr (AW'(idx)),
    .wdata (val),
    .re    (ctrl.mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign a_sel = (op == csr_smv_pkg::CMD_END_ROW) ? row_sum : {{HW{val[VW-1]}}, val};
  assign ua    = a_sel[SW-1] ? (~a_sel + 1'b1) : a_sel;

  assign mul_a = ctrl.mul_hi ? VW'(ah) : al;
  assign prod  = PW'(mul_a) * PW'(ub);

  assign mag = {p_hi, {FW{1'b0}}} + {{FW{1'b0}}, p_lo[PW-1:FW]};

  always_comb begin
    term_sat_next = 1'b0;
    if (neg) begin
      if (mag > csr_smv_pkg::MAG_LIMIT) begin
        term_next     = csr_smv_pkg::SUM_MIN;
        term_sat_next = 1'b1;
      end else begin
        term_next = -$signed(mag[SW-1:0]);
      end
    end else begin
      if (mag > csr_smv_pkg::MAG_LIMIT - PW'(1)) begin
        term_next     = csr_smv_pkg::SUM_MAX;
        term_sat_next = 1'b1;
      end else begin
        term_next = $signed(mag[SW-1:0]);
      end
    end
  end

  assign acc_sel  = (op == csr_smv_pkg::CMD_END_ROW) ? dot_sum : row_sum;
  assign acc_wide = {acc_sel[SW-1], acc_sel} + {term[SW-1], term};

  always_comb begin
    add_sat  = 1'b0;
    acc_next = acc_wide[SW-1:0];
    if (acc_wide[SW] != acc_wide[SW-1]) begin
      add_sat  = 1'b1;
      acc_next = acc_wide[SW] ? csr_smv_pkg::SUM_MIN : csr_smv_pkg::SUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      op  <= csr_smv_pkg::cmd_t'(cmd);
      idx <= index;
      val <= value;
    end
    if (ctrl.abs_en) begin
      neg <= a_sel[SW-1] ^ rdata[VW-1];
      ah  <= ua[SW-1:VW];
      al  <= ua[VW-1:0];
      ub  <= rdata[VW-1] ? (~rdata + 1'b1) : rdata;
    end
    if (ctrl.mul_lo) begin
      p_lo <= prod;
    end
    if (ctrl.mul_hi) begin
      p_hi <= prod[SW-1:0];
    end
    if (ctrl.scale) begin
      term     <= term_next;
      term_sat <= term_sat_next;
    end
    if (ctrl.emit) begin
      row_index <= csr_smv_pkg::INDEX_W'(row_counter);
      row_value <= row_sum;
      dot_value <= acc_next;
      saturated <= sat_flag | term_sat | add_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum     <= '0;
      dot_sum     <= '0;
      row_counter <= '0;
      sat_flag    <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= ctrl.emit;
      if (ctrl.clear_all) begin
        row_sum     <= '0;
        dot_sum     <= '0;
        row_counter <= '0;
        sat_flag    <= 1'b0;
      end else if (ctrl.clear_row) begin
        row_sum <= '0;
      end else if (ctrl.accum) begin
        sat_flag <= sat_flag | term_sat | add_sat;
        if (op == csr_smv_pkg::CMD_END_ROW) begin
          dot_sum     <= acc_next;
          row_sum     <= '0;
          row_counter <= row_counter + CW'(1);
        end else begin
          row_sum <= acc_next;
        end
      end
    end
  end

endmodule

/* rtl/core/csr_sparse_matvec_dot_core.sv */
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector dot core
// Computes A*x one row at a time and a running dot product of the result and x.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge where start is high and busy is
// low; cmd selects load element, nonzero term, end of row or new product.
// A load writes an in-range element to the vector store and a new product
// clears the sums. A nonzero term or an end of row goes through a read of the
// vector store, a magnitude step, two passes through one shared 32x32
// multiplier, a scaling and clamp step, and a saturating accumulate.
// Out-of-range terms and rows past the depth return to idle after the read.
// An end of row within the depth gives one result: done is high for exactly
// one cycle in the cycle after its last step, with row_index, row_value,
// dot_value and saturated valid during that cycle. The result registers are
// separate, so the next command may be transferred while done is high.
// The receiver cannot hold results off and none is ever needed to.
// Reset clears the sums, the row counter, the saturation flag and the
// controller; the vector store holds no defined data until it is loaded.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_dot_core #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              cmd,
  input  logic [csr_smv_pkg::INDEX_W-1:0]         index,
  input  logic signed [csr_smv_pkg::VALUE_W-1:0]  value,
  output logic                                    done,
  output logic [csr_smv_pkg::INDEX_W-1:0]         row_index,
  output logic signed [csr_smv_pkg::SUM_W-1:0]    row_value,
  output logic signed [csr_smv_pkg::SUM_W-1:0]    dot_value,
  output logic                                    saturated
);

  csr_smv_pkg::ctrl_t   ctrl;
  csr_smv_pkg::status_t status;

  csr_smv_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  csr_smv_dp #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cmd       (cmd),
    .index     (index),
    .value     (value),
    .row_index (row_index),
    .row_value (row_value),
    .dot_value (dot_value),
    .saturated (saturated),
    .done      (done)
  );

endmodule

/* rtl/core/csr_smv_checker.sv */
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector dot core: port checker
// Checks command and result timing as seen on the top-level ports.
// ----------------------------------------------------------------------------
module csr_smv_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Core did not go busy after a command transfer.");

  a_no_early_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("Result strobe appeared right after a command transfer.");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobe appeared while the core was busy.");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe lasted longer than one cycle.");

endmodule

bind csr_sparse_matvec_dot_core csr_smv_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* tb/tb_csr_sparse_matvec_dot_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CSR sparse matrix-vector dot core
// Streams load, nonzero term, end-of-row and new-product commands through the
// start/busy handshake with random gaps. A built-in fixed-point predictor
// computes each finished row and the running dot sum. Every result strobe is
// checked field by field against the oldest predicted row.
// ----------------------------------------------------------------------------
module tb_csr_sparse_matvec_dot_core;

  localparam int DEPTH       = 1024;
  localparam int VEC_USED    = 128;
  localparam int RAND_ITEMS  = 1000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    csr_smv_pkg::cmd_t op;
    logic [9:0]        idx;
    logic [31:0]       val;
    int                gap;
  } cmd_item_t;

  typedef struct {
    logic [9:0]         row;
    logic signed [47:0] row_sum;
    logic signed [47:0] dot_sum;
    logic               sat;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = csr_smv_pkg::CMD_LOAD;
  logic [9:0] index = '0;
  logic signed [31:0] value = '0;
  logic busy;
  logic done;
  logic [9:0] row_index;
  logic signed [47:0] row_value;
  logic signed [47:0] dot_value;
  logic saturated;

  cmd_item_t   command_q[$];
  row_result_t expected_rows[$];

  logic signed [31:0] x_vec [DEPTH];
  logic signed [47:0] row_acc = '0;
  logic signed [47:0] dot_acc = '0;
  int                 rows_done = 0;
  logic               sat_seen = 1'b0;

  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 0;
  int gen_rows = 0;
  int cycle_count = 0;

  csr_sparse_matvec_dot_core #(.VECTOR_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .index(index),
    .value(value),
    .done(done),
    .row_index(row_index),
    .row_value(row_value),
    .dot_value(dot_value),
    .saturated(saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The product is floored in magnitude, so it truncates toward zero, then
  // it is clamped to the 48-bit signed range.
  function automatic logic signed [47:0] scaled_mul(input logic signed [47:0] a,
                                                    input logic signed [31:0] b);
    logic signed [79:0] sa;
    logic signed [79:0] sb;
    logic [79:0] ua;
    logic [79:0] ub;
    logic [79:0] mag;
    logic neg;
    sa = a;
    sb = b;
    neg = a[47] ^ b[31];
    ua = sa[79] ? -sa : sa;
    ub = sb[79] ? -sb : sb;
    mag = (ua * ub) >> csr_smv_pkg::FRAC_W;
    if (neg) begin
      if (mag > 80'(csr_smv_pkg::MAG_LIMIT)) begin
        mag = 80'(csr_smv_pkg::MAG_LIMIT);
        sat_seen = 1'b1;
      end
      return 48'(-mag);
    end
    if (mag > 80'(csr_smv_pkg::MAG_LIMIT) - 80'd1) begin
      mag = 80'(csr_smv_pkg::MAG_LIMIT) - 80'd1;
      sat_seen = 1'b1;
    end
    return 48'(mag);
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
    logic signed [48:0] s;
    s = a + b;
    if (s > csr_smv_pkg::SUM_MAX) begin
      sat_seen = 1'b1;
      return csr_smv_pkg::SUM_MAX;
    end
    if (s < csr_smv_pkg::SUM_MIN) begin
      sat_seen = 1'b1;
      return csr_smv_pkg::SUM_MIN;
    end
    return s[47:0];
  endfunction

  task automatic predict_command(input csr_smv_pkg::cmd_t op, input logic [9:0] idx,
                                 input logic signed [31:0] val);
    row_result_t r;
    case (op)
      csr_smv_pkg::CMD_LOAD: begin
        x_vec[idx] = val;
      end
      csr_smv_pkg::CMD_TERM: begin
        row_acc = sat_add(row_acc, scaled_mul(48'(val), x_vec[idx]));
      end
      csr_smv_pkg::CMD_START: begin
        row_acc = '0;
        dot_acc = '0;
        rows_done = 0;
        sat_seen = 1'b0;
      end
      default: begin
        if (rows_done >= DEPTH) begin
          row_acc = '0;
        end else begin
          dot_acc = sat_add(dot_acc, scaled_mul(row_acc, x_vec[rows_done]));
          r.row = rows_done[9:0];
          r.row_sum = row_acc;
          r.dot_sum = dot_acc;
          r.sat = sat_seen;
          expected_rows.push_back(r);
          row_acc = '0;
          rows_done++;
        end
      end
    endcase
  endtask

  task automatic queue_item(input csr_smv_pkg::cmd_t op, input logic [9:0] idx,
                            input logic [31:0] val);
    cmd_item_t it;
    it.op = op;
    it.idx = idx;
    it.val = val;
    if (op == csr_smv_pkg::CMD_START) begin
      gen_rows = 0;
    end else if (op == csr_smv_pkg::CMD_END_ROW) begin
      gen_rows++;
    end
    if (burst_left > 0) begin
      burst_left--;
      it.gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 40);
      it.gap = $urandom_range(0, 13);
    end
    command_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h001F_FFFF);
        v = v - 32'h0010_0000;
      end
    endcase
    return v;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Driver: holds an item until busy is low, then waits out the item's gap.
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) predict_command(csr_smv_pkg::cmd_t'(cmd), index, value);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (command_q.size() != 0) begin
          nxt = command_q.pop_front();
          cmd <= nxt.op;
          index <= nxt.idx;
          value <= nxt.val;
          start <= 1'b1;
          gap_left = nxt.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    row_result_t e;
    if (!rst && done) begin
      if (expected_rows.size() == 0) begin
        note_mismatch("row_index of a result with none expected", -1, row_index);
      end else begin
        e = expected_rows.pop_front();
        if (row_index !== e.row) note_mismatch("row_index", e.row, row_index);
        if (row_value !== e.row_sum)
          note_mismatch("row_value", longint'(e.row_sum), longint'(row_value));
        if (dot_value !== e.dot_sum)
          note_mismatch("dot_value", longint'(e.dot_sum), longint'(dot_value));
        if (saturated !== e.sat) note_mismatch("saturated", e.sat, saturated);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int base;
    int rows;
    int terms;
    int roll;
    csr_smv_pkg::cmd_t op;

    // Terms ahead of any new-product command use the sums cleared by reset.
    queue_item(csr_smv_pkg::CMD_LOAD, 10'd0, 32'h0001_0000);
    queue_item(csr_smv_pkg::CMD_TERM, 10'd0, 32'h7FFF_FFFF);
    queue_item(csr_smv_pkg::CMD_END_ROW, 10'd1023, $urandom);
    queue_item(csr_smv_pkg::CMD_START, 10'($urandom_range(0, 1023)), $urandom);
    queue_item(csr_smv_pkg::CMD_END_ROW, 10'd0, 32'h0);
    queue_item(csr_smv_pkg::CMD_LOAD, 10'd1023, 32'h8000_0000);
    queue_item(csr_smv_pkg::CMD_LOAD, 10'd1, 32'h7FFF_FFFF);
    queue_item(csr_smv_pkg::CMD_TERM, 10'd1023, 32'h8000_0000);
    queue_item(csr_smv_pkg::CMD_TERM, 10'd1023, 32'h8000_0000);
    queue_item(csr_smv_pkg::CMD_END_ROW, 10'd0, 32'h0);
    queue_item(csr_smv_pkg::CMD_START, 10'd0, 32'h0);
    repeat (3) queue_item(csr_smv_pkg::CMD_TERM, 10'd1, 32'h8000_0000);
    queue_item(csr_smv_pkg::CMD_END_ROW, 10'd0, 32'h0);
    repeat (3) queue_item(csr_smv_pkg::CMD_TERM, 10'd1, 32'h8000_0000);
    queue_item(csr_smv_pkg::CMD_END_ROW, 10'd0, 32'h0);
    queue_item(csr_smv_pkg::CMD_LOAD, 10'd2, 32'hFFFF_0000);
    queue_item(csr_smv_pkg::CMD_TERM, 10'd0, 32'hFFFF_FFFF);
    queue_item(csr_smv_pkg::CMD_END_ROW, 10'd0, 32'h0);

    // Fill the low part of the vector that the random products read.
    queue_item(csr_smv_pkg::CMD_START, 10'd0, 32'h0);
    for (int i = 0; i < VEC_USED; i++) begin
      queue_item(csr_smv_pkg::CMD_LOAD, i[9:0], pick_value());
    end

    base = command_q.size();
    while (command_q.size() - base < RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_item(csr_smv_pkg::CMD_LOAD, 10'($urandom_range(0, 1023)), pick_value());
      end else if (roll < 13) begin
        op = csr_smv_pkg::cmd_t'($urandom_range(0, 3));
        if (op == csr_smv_pkg::CMD_END_ROW && gen_rows >= VEC_USED) begin
          op = csr_smv_pkg::CMD_START;
        end
        queue_item(op, 10'($urandom_range(0, VEC_USED - 1)), $urandom);
      end else begin
        queue_item(csr_smv_pkg::CMD_START, 10'($urandom_range(0, 1023)), $urandom);
        rows = $urandom_range(1, 12);
        for (int r = 0; r < rows; r++) begin
          terms = $urandom_range(0, 6);
          for (int t = 0; t < terms; t++) begin
            if ($urandom_range(0, 19) == 0)
              queue_item(csr_smv_pkg::CMD_LOAD, 10'($urandom_range(0, 1023)), pick_value());
            queue_item(csr_smv_pkg::CMD_TERM, 10'($urandom_range(0, VEC_USED - 1)),
                       pick_value());
          end
          queue_item(csr_smv_pkg::CMD_END_ROW, 10'($urandom_range(0, 1023)), $urandom);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (command_q.size() != 0 || start || expected_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
